@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds on every clock edge outside reset
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// expression never true outside reset
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr, msg)

`endif

`endif

@@ rtl/core/tcnq_pkg.sv @@
// ---------------------------------------------------------------------------
// tcnq_pkg
// Types, note table and search helper for the tracker cell note quantizer.
// ---------------------------------------------------------------------------
package tcnq_pkg;

  localparam int NOTE_COUNT         = 12;
  localparam int OCTAVE_COUNT       = 5;
  localparam int TICK_FRACTION_BITS = 4;

  localparam int PERIOD_W = 12;
  localparam int ENTRY_W  = 11;
  localparam int BASE_W   = 10;
  localparam int NOTE_W   = 4;
  localparam int OCT_W    = 3;
  localparam int SAMPLE_W = 8;
  localparam int DUR_W    = 16;

  localparam logic [NOTE_W-1:0] PAUSE_NOTE   = 4'd12;
  localparam logic [OCT_W-1:0]  PAUSE_OCTAVE = 3'd1;
  localparam logic [OCT_W-1:0]  LAST_OCTAVE  = 3'(OCTAVE_COUNT - 1);

  localparam logic [DUR_W-1:0] DURATION_TICKS = DUR_W'(32'd4 << TICK_FRACTION_BITS);

  // base periods, doubled for octave 0 and halved once per octave after that
  localparam logic [BASE_W-1:0] BASE_PERIOD [NOTE_COUNT] = '{
    10'd856, 10'd808, 10'd762, 10'd720, 10'd678, 10'd640,
    10'd604, 10'd570, 10'd538, 10'd508, 10'd480, 10'd453
  };

  typedef struct packed {
    logic [PERIOD_W-1:0] delta;
    logic [NOTE_W-1:0]   note;
  } oct_min_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [SAMPLE_W-1:0] sample;
    logic [PERIOD_W-1:0] best;
    logic [NOTE_W-1:0]   note;
    logic [OCT_W-1:0]    octave;
  } stage_t;

  // nearest note within one octave; ties keep the lower note
  function automatic oct_min_t oct_search(logic [PERIOD_W-1:0] period,
                                          logic [OCT_W-1:0] oct);
    logic [ENTRY_W-1:0] entry;
    oct_min_t           l0 [12];
    oct_min_t           l1 [6];
    oct_min_t           l2 [3];
    oct_min_t           l3;
    oct_min_t           res;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      entry = {BASE_PERIOD[i], 1'b0} >> oct;
      l0[i].note  = NOTE_W'(i);
      l0[i].delta = (period >= {1'b0, entry}) ? period - {1'b0, entry}
                                              : {1'b0, entry} - period;
    end
    for (int j = 0; j < 6; j++) begin
      l1[j] = (l0[2*j+1].delta < l0[2*j].delta) ? l0[2*j+1] : l0[2*j];
    end
    for (int j = 0; j < 3; j++) begin
      l2[j] = (l1[2*j+1].delta < l1[2*j].delta) ? l1[2*j+1] : l1[2*j];
    end
    l3  = (l2[1].delta < l2[0].delta) ? l2[1] : l2[0];
    res = (l2[2].delta < l3.delta) ? l2[2] : l3;
    return res;
  endfunction

endpackage

@@ rtl/core/tracker_cell_note_quantizer_unit.sv @@
// ---------------------------------------------------------------------------
// tracker_cell_note_quantizer_unit
// Pattern cell decode: period to nearest note and octave, sample number.
// ---------------------------------------------------------------------------
// Takes one item per cycle while in_stall is low and returns one result
// per item. The pipeline has one stage per octave of the note table:
// each stage measures the period against that octave's twelve notes and
// keeps the nearest entry seen so far (earlier octave and lower note win
// ties). The last stage is the output register; stages holding no item let
// new items in while a result waits on a stalled output.
module tracker_cell_note_quantizer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_cell_byte_first,
  input  logic [7:0]                   in_cell_byte_second,
  input  logic [7:0]                   in_cell_byte_third,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcnq_pkg::NOTE_W-1:0]   out_note_index,
  output logic [tcnq_pkg::OCT_W-1:0]    out_octave_index,
  output logic [tcnq_pkg::SAMPLE_W-1:0] out_sample_number,
  output logic [tcnq_pkg::DUR_W-1:0]    out_duration_ticks
);
  import tcnq_pkg::*;

  `include "assert_macros.svh"

  logic [OCTAVE_COUNT-1:0] valid_r;
  logic [OCTAVE_COUNT-1:0] adv;
  stage_t                  stage_r [OCTAVE_COUNT];
  stage_t                  src     [OCTAVE_COUNT];
  stage_t                  stage_nxt [OCTAVE_COUNT];
  oct_min_t                cand    [OCTAVE_COUNT];

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[OCTAVE_COUNT-1] = !valid_r[OCTAVE_COUNT-1] || !out_stall;
    for (int k = OCTAVE_COUNT - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  always_comb begin
    src[0].period = {in_cell_byte_first[3:0], in_cell_byte_second};
    src[0].sample = {in_cell_byte_first[7:4], in_cell_byte_third[7:4]};
    src[0].best   = '0;
    src[0].note   = '0;
    src[0].octave = '0;
    for (int k = 1; k < OCTAVE_COUNT; k++) begin
      src[k] = stage_r[k-1];
    end
    for (int k = 0; k < OCTAVE_COUNT; k++) begin
      cand[k]      = oct_search(src[k].period, OCT_W'(k));
      stage_nxt[k] = src[k];
      if (k == 0 || cand[k].delta < src[k].best) begin
        stage_nxt[k].best   = cand[k].delta;
        stage_nxt[k].note   = cand[k].note;
        stage_nxt[k].octave = OCT_W'(k);
      end
    end
    // zero period is a pause
    if (src[OCTAVE_COUNT-1].period == '0) begin
      stage_nxt[OCTAVE_COUNT-1].note   = PAUSE_NOTE;
      stage_nxt[OCTAVE_COUNT-1].octave = PAUSE_OCTAVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < OCTAVE_COUNT; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < OCTAVE_COUNT; k++) begin
      if (adv[k]) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
  end

  assign out_valid          = valid_r[OCTAVE_COUNT-1];
  assign out_note_index     = stage_r[OCTAVE_COUNT-1].note;
  assign out_octave_index   = stage_r[OCTAVE_COUNT-1].octave;
  assign out_sample_number  = stage_r[OCTAVE_COUNT-1].sample;
  assign out_duration_ticks = DURATION_TICKS;

  `ASSERT_PROP(a_stall_only_when_full, clk, rst_n, in_stall |-> valid_r[0],
               "input stalled with empty first stage")
  `ASSERT_PROP(a_mid_stage_holds, clk, rst_n,
               (valid_r[2] && !adv[2]) |=> (valid_r[2] && $stable(stage_r[2])),
               "held stage changed")
  `ASSERT_PROP(a_pause_octave, clk, rst_n,
               (out_valid && out_note_index == PAUSE_NOTE) |-> (out_octave_index == PAUSE_OCTAVE),
               "pause with wrong octave")
  `ASSERT_NEVER(a_note_range, clk, rst_n,
                out_valid && (out_note_index > PAUSE_NOTE || out_octave_index > LAST_OCTAVE),
                "result out of range")

endmodule
